### src/rpr_pkg.sv
// Shared types, widths, register indexes and rounding helper for the pose residual block
`default_nettype none
package rpr_pkg;

   localparam int QW      = 32;
   localparam int ROT_W   = 34;
   localparam int ROOT_W  = 31;
   localparam int RAD_W   = 61;
   localparam int QUO_W   = 31;
   localparam int DIVD_W  = 60;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_OBS_TX = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OBS_TY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OBS_TZ = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OBS_RW = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OBS_RX = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OBS_RY = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OBS_RZ = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT = 3'd7;

   typedef logic [3:0][QW-1:0] quat_type;
   typedef logic [3:0][ROT_W-1:0] relq_type;
   typedef logic [8:0][ROT_W-1:0] rmat_type;

   // round half away from zero, then shift right by s
   function automatic logic signed [95:0] rnd_shr(input logic signed [95:0] p,
                                                  input int unsigned s);
      logic [95:0] m;
      logic [95:0] r;
      m = p[95] ? 96'(-p) : 96'(p);
      r = (m + (96'd1 << (s - 1))) >> s;
      return p[95] ? -$signed(r) : $signed(r);
   endfunction

endpackage
`default_nettype wire

### src/rpr_norm.sv
// Pipelined normalization of two quaternions: square root and restoring division stages
`default_nettype none
module rpr_norm
   import rpr_pkg::*;
#(
   parameter int SIDE_W = 99
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [127:0]      in_quat,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output quat_type [1:0]    out_quat,
   output logic [SIDE_W-1:0] out_side
);

   logic                          sv_ff    [ROOT_W+1];
   logic [127:0]                  sraw_ff  [ROOT_W+1];
   logic [SIDE_W-1:0]             sside_ff [ROOT_W+1];
   logic [1:0][RAD_W-1:0]         srem_ff  [ROOT_W+1];
   logic [1:0][ROOT_W-1:0]        sroot_ff [ROOT_W+1];

   logic                          dv_ff    [QUO_W+1];
   logic [SIDE_W-1:0]             dside_ff [QUO_W+1];
   logic [1:0][3:0][DIVD_W-1:0]   drem_ff  [QUO_W+1];
   logic [1:0][3:0][QUO_W-1:0]    dquo_ff  [QUO_W+1];
   logic [1:0][ROOT_W-1:0]        dn_ff    [QUO_W+1];
   logic [1:0][3:0]               dneg_ff  [QUO_W+1];

   logic                          ov_ff;
   quat_type [1:0]                oq_ff;
   logic [SIDE_W-1:0]             oside_ff;

   logic [1:0][32:0]              sq_in;
   logic [1:0][3:0][DIVD_W-1:0]   divd_in;
   logic [1:0][3:0]               neg_in;
   quat_type [1:0]                oq_in;

   always_comb begin
      logic signed [15:0] c;
      logic signed [31:0] c2;
      for (int q = 0; q < 2; q++) begin
         sq_in[q] = '0;
         for (int i = 0; i < 4; i++) begin
            c        = in_quat[q*64 + 48 - 16*i +: 16];
            c2       = c * c;
            sq_in[q] = sq_in[q] + 33'(unsigned'(c2));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else if (adv) begin
         sv_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sraw_ff[0]  <= in_quat;
         sside_ff[0] <= in_side;
         for (int q = 0; q < 2; q++) begin
            srem_ff[0][q]  <= {sq_in[q], 28'b0};
            sroot_ff[0][q] <= '0;
         end
      end
   end

   for (genvar j = 1; j <= ROOT_W; j++) begin : g_sqrt
      localparam int K = ROOT_W - j;
      logic [1:0][RAD_W-1:0]  rem_in;
      logic [1:0][ROOT_W-1:0] root_in;

      always_comb begin
         logic [RAD_W:0] t;
         for (int q = 0; q < 2; q++) begin
            t = ((RAD_W+1)'(sroot_ff[j-1][q]) << (K + 1)) + ((RAD_W+1)'(1) << (2 * K));
            if ((RAD_W+1)'(srem_ff[j-1][q]) >= t) begin
               rem_in[q]  = srem_ff[j-1][q] - t[RAD_W-1:0];
               root_in[q] = sroot_ff[j-1][q] | (ROOT_W'(1) << K);
            end else begin
               rem_in[q]  = srem_ff[j-1][q];
               root_in[q] = sroot_ff[j-1][q];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[j] <= 1'b0;
         end else if (adv) begin
            sv_ff[j] <= sv_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sraw_ff[j]  <= sraw_ff[j-1];
            sside_ff[j] <= sside_ff[j-1];
            srem_ff[j]  <= rem_in;
            sroot_ff[j] <= root_in;
         end
      end
   end

   always_comb begin
      logic [15:0] c;
      logic [15:0] mag;
      for (int q = 0; q < 2; q++) begin
         for (int i = 0; i < 4; i++) begin
            c             = sraw_ff[ROOT_W][q*64 + 48 - 16*i +: 16];
            mag           = c[15] ? 16'(-c) : c;
            neg_in[q][i]  = c[15];
            divd_in[q][i] = {mag, 44'b0} + DIVD_W'(sroot_ff[ROOT_W][q] >> 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= sv_ff[ROOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dside_ff[0] <= sside_ff[ROOT_W];
         drem_ff[0]  <= divd_in;
         dquo_ff[0]  <= '0;
         dn_ff[0]    <= sroot_ff[ROOT_W];
         dneg_ff[0]  <= neg_in;
      end
   end

   for (genvar j = 1; j <= QUO_W; j++) begin : g_div
      localparam int K = QUO_W - j;
      logic [1:0][3:0][DIVD_W-1:0] rem_in;
      logic [1:0][3:0][QUO_W-1:0]  quo_in;

      always_comb begin
         logic [DIVD_W+1:0] t;
         for (int q = 0; q < 2; q++) begin
            t = (DIVD_W+2)'(dn_ff[j-1][q]) << K;
            for (int i = 0; i < 4; i++) begin
               if ((DIVD_W+2)'(drem_ff[j-1][q][i]) >= t) begin
                  rem_in[q][i] = drem_ff[j-1][q][i] - t[DIVD_W-1:0];
                  quo_in[q][i] = dquo_ff[j-1][q][i] | (QUO_W'(1) << K);
               end else begin
                  rem_in[q][i] = drem_ff[j-1][q][i];
                  quo_in[q][i] = dquo_ff[j-1][q][i];
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_ff[j] <= dv_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dside_ff[j] <= dside_ff[j-1];
            drem_ff[j]  <= rem_in;
            dquo_ff[j]  <= quo_in;
            dn_ff[j]    <= dn_ff[j-1];
            dneg_ff[j]  <= dneg_ff[j-1];
         end
      end
   end

   always_comb begin
      for (int q = 0; q < 2; q++) begin
         for (int i = 0; i < 4; i++) begin
            if (dn_ff[QUO_W][q] == '0) begin
               oq_in[q][i] = '0;
            end else begin
               oq_in[q][i] = dneg_ff[QUO_W][q][i] ? QW'(-QW'(dquo_ff[QUO_W][q][i]))
                                                  : QW'(dquo_ff[QUO_W][q][i]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (adv) begin
         ov_ff <= dv_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         oq_ff    <= oq_in;
         oside_ff <= dside_ff[QUO_W];
      end
   end

   assign out_valid = ov_ff;
   assign out_quat  = oq_ff;
   assign out_side  = oside_ff;

endmodule
`default_nettype wire

### src/rpr_geom.sv
// Relative rotation and transposed rotation matrix of the first pose, two stages
`default_nettype none
module rpr_geom
   import rpr_pkg::*;
#(
   parameter int TRANS_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  quat_type [1:0]                in_quat,
   input  logic [2:0][TRANS_WIDTH:0]     in_dv,
   output logic                          out_valid,
   output relq_type                      out_rel,
   output rmat_type                      out_rt,
   output logic [2:0][TRANS_WIDTH:0]     out_dv
);

   localparam int SA [9] = '{1, 2, 3, 1, 1, 2, 0, 0, 0};
   localparam int SB [9] = '{1, 2, 3, 2, 3, 3, 1, 2, 3};

   logic                        v1_ff;
   logic signed [2*QW-1:0]      pr_ff [16];
   logic signed [2*QW-1:0]      ps_ff [9];
   logic [2:0][TRANS_WIDTH:0]   dv1_ff;

   logic                        v2_ff;
   relq_type                    rel_ff;
   rmat_type                    rt_ff;
   logic [2:0][TRANS_WIDTH:0]   dv2_ff;

   logic signed [2*QW-1:0]      pr_in [16];
   logic signed [2*QW-1:0]      ps_in [9];
   relq_type                    rel_in;
   rmat_type                    rt_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            pr_in[4*i+j] = $signed(in_quat[0][i]) * $signed(in_quat[1][j]);
         end
      end
      for (int k = 0; k < 9; k++) begin
         ps_in[k] = $signed(in_quat[0][SA[k]]) * $signed(in_quat[0][SB[k]]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pr_ff  <= pr_in;
         ps_ff  <= ps_in;
         dv1_ff <= in_dv;
      end
   end

   always_comb begin
      logic signed [35:0] r [16];
      logic signed [35:0] s [9];
      logic signed [35:0] one;
      one = 36'sd1 <<< 30;
      for (int k = 0; k < 16; k++) begin
         r[k] = 36'(rnd_shr(96'(pr_ff[k]), 30));
      end
      for (int k = 0; k < 9; k++) begin
         s[k] = 36'(rnd_shr(96'(ps_ff[k]), 30));
      end
      rel_in[0] = ROT_W'(r[0] + r[5] + r[10] + r[15]);
      rel_in[1] = ROT_W'(r[1] - r[4] - r[11] + r[14]);
      rel_in[2] = ROT_W'(r[2] + r[7] - r[8] - r[13]);
      rel_in[3] = ROT_W'(r[3] - r[6] + r[9] - r[12]);
      // s: xx yy zz xy xz yz wx wy wz
      rt_in[0] = ROT_W'(one - 2 * (s[1] + s[2]));
      rt_in[1] = ROT_W'(2 * (s[3] + s[8]));
      rt_in[2] = ROT_W'(2 * (s[4] - s[7]));
      rt_in[3] = ROT_W'(2 * (s[3] - s[8]));
      rt_in[4] = ROT_W'(one - 2 * (s[0] + s[2]));
      rt_in[5] = ROT_W'(2 * (s[5] + s[6]));
      rt_in[6] = ROT_W'(2 * (s[4] + s[7]));
      rt_in[7] = ROT_W'(2 * (s[5] - s[6]));
      rt_in[8] = ROT_W'(one - 2 * (s[0] + s[1]));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rel_ff <= rel_in;
         rt_ff  <= rt_in;
         dv2_ff <= dv1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_rel   = rel_ff;
   assign out_rt    = rt_ff;
   assign out_dv    = dv2_ff;

endmodule
`default_nettype wire

### src/rpr_resid.sv
// Residual stages: translation rotate, rotation error, weighting, rounding and saturation
`default_nettype none
module rpr_resid
   import rpr_pkg::*;
#(
   parameter int TRANS_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  relq_type                        in_rel,
   input  rmat_type                        in_rt,
   input  logic [2:0][TRANS_WIDTH:0]       in_dv,
   input  logic [2:0][TRANS_WIDTH-1:0]     obs_trans,
   input  logic [3:0][15:0]                obs_rot,
   input  logic [15:0]                     weight,
   output logic                            out_valid,
   output logic [2:0][TRANS_WIDTH-1:0]     out_trans,
   output logic [2:0][31:0]                out_rot
);

   localparam int TPW = ROT_W + TRANS_WIDTH + 1;
   localparam int OPW = 16 + ROT_W;
   localparam int RW  = TRANS_WIDTH + 7;
   localparam int EW  = 38;
   localparam int WPW = RW + 17;
   localparam int EPW = EW + 18;
   localparam logic signed [95:0] T_HI = (96'sd1 <<< (TRANS_WIDTH - 1)) - 96'sd1;
   localparam logic signed [95:0] T_LO = -T_HI - 96'sd1;
   localparam logic signed [95:0] R_HI = (96'sd1 <<< 31) - 96'sd1;
   localparam logic signed [95:0] R_LO = -R_HI - 96'sd1;

   localparam int OA  [12] = '{0, 1, 2, 3, 0, 1, 2, 3, 0, 1, 2, 3};
   localparam int RA  [12] = '{1, 0, 3, 2, 2, 3, 0, 1, 3, 2, 1, 0};
   localparam bit OSG [12] = '{0, 1, 1, 0, 0, 0, 1, 1, 0, 1, 0, 1};

   logic                   v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [TPW-1:0]  tp_ff [9];
   logic signed [OPW-1:0]  op_ff [12];
   logic signed [RW-1:0]   rr_ff [3];
   logic signed [EW-1:0]   err_ff [3];
   logic signed [WPW-1:0]  wp_ff [3];
   logic signed [EPW-1:0]  ep_ff [3];
   logic [2:0][TRANS_WIDTH-1:0] tr_ff;
   logic [2:0][31:0]       ro_ff;

   logic signed [TPW-1:0]  tp_in [9];
   logic signed [OPW-1:0]  op_in [12];
   logic signed [RW-1:0]   rr_in [3];
   logic signed [EW-1:0]   err_in [3];
   logic signed [WPW-1:0]  wp_in [3];
   logic signed [EPW-1:0]  ep_in [3];
   logic [2:0][TRANS_WIDTH-1:0] tr_in;
   logic [2:0][31:0]       ro_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            tp_in[3*i+j] = $signed(in_rt[3*i+j]) * $signed(in_dv[j]);
         end
      end
      for (int k = 0; k < 12; k++) begin
         op_in[k] = $signed(obs_rot[OA[k]]) * $signed(in_rel[RA[k]]);
      end
   end

   always_comb begin
      logic signed [RW-1:0] est;
      logic signed [EW-1:0] e;
      for (int i = 0; i < 3; i++) begin
         est = '0;
         for (int j = 0; j < 3; j++) begin
            est = est + RW'(rnd_shr(96'(tp_ff[3*i+j]), 30));
         end
         rr_in[i] = est - RW'($signed(obs_trans[i]));
         e = '0;
         for (int m = 0; m < 4; m++) begin
            if (OSG[4*i+m]) begin
               e = e - EW'(rnd_shr(96'(op_ff[4*i+m]), 14));
            end else begin
               e = e + EW'(rnd_shr(96'(op_ff[4*i+m]), 14));
            end
         end
         err_in[i] = e;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wp_in[i] = rr_ff[i] * $signed({1'b0, weight});
         ep_in[i] = err_ff[i] * $signed({1'b0, weight, 1'b0});
      end
   end

   always_comb begin
      logic signed [95:0] x;
      logic signed [95:0] y;
      for (int i = 0; i < 3; i++) begin
         x = rnd_shr(96'(wp_ff[i]), 8);
         y = rnd_shr(96'(ep_ff[i]), 22);
         if (x > T_HI) begin
            tr_in[i] = T_HI[TRANS_WIDTH-1:0];
         end else if (x < T_LO) begin
            tr_in[i] = T_LO[TRANS_WIDTH-1:0];
         end else begin
            tr_in[i] = x[TRANS_WIDTH-1:0];
         end
         if (y > R_HI) begin
            ro_in[i] = R_HI[31:0];
         end else if (y < R_LO) begin
            ro_in[i] = R_LO[31:0];
         end else begin
            ro_in[i] = y[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tp_ff  <= tp_in;
         op_ff  <= op_in;
         rr_ff  <= rr_in;
         err_ff <= err_in;
         wp_ff  <= wp_in;
         ep_ff  <= ep_in;
         tr_ff  <= tr_in;
         ro_ff  <= ro_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_trans = tr_ff;
   assign out_rot   = ro_ff;

endmodule
`default_nettype wire

### src/relative_pose_residual_top.sv
// Top level of the pose-graph edge residual engine: ports, registers, entry and output stages
//
//  channel | direction | handshake                    | payload
//  req     | in        | req_tvalid / req_tready      | req_tdata: two quaternions, two translations
//  rsp     | out       | rsp_tvalid / rsp_tready      | rsp_tdata: six weighted residuals
//  csr     | in        | csr_valid / csr_ready        | csr_index, csr_wdata
//
//  One request per cycle while the skid is empty. Each request passes the entry register and the
//  31 square root and 31 division stages of the normalizer, then the geometry and residual stages.
//  Synchronous active-high reset clears all valid bits and loads register defaults.
//  A response not taken goes to a one-entry skid; req_tready drops while it is full.
//  csr_ready is always high.
`default_nettype none
module relative_pose_residual_top
   import rpr_pkg::*;
#(
   parameter int TRANS_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // rot_first, rot_second, t_first_x, t_first_y, t_first_z, t_second_x, t_second_y,
   // t_second_z
   input  logic [((128+6*TRANS_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // res_trans_x, res_trans_y, res_trans_z, res_rot_x, res_rot_y, res_rot_z
   output logic [((96+3*TRANS_WIDTH+7)/8)*8-1:0]  rsp_tdata,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [TRANS_WIDTH-1:0]     csr_wdata
);

   localparam int RSP_W = ((96 + 3*TRANS_WIDTH + 7) / 8) * 8;
   localparam int DV_W  = TRANS_WIDTH + 1;

   logic [2:0][TRANS_WIDTH-1:0] obs_t_ff;
   logic [3:0][15:0]            obs_r_ff;
   logic [15:0]                 weight_ff;

   logic                        e_v_ff;
   logic [127:0]                e_quat_ff;
   logic [2:0][DV_W-1:0]        e_dv_ff;
   logic [2:0][DV_W-1:0]        e_dv_in;

   logic                        adv;
   logic                        n_v;
   quat_type [1:0]              n_quat;
   logic [3*DV_W-1:0]           n_side;
   logic                        g_v;
   relq_type                    g_rel;
   rmat_type                    g_rt;
   logic [2:0][DV_W-1:0]        g_dv;
   logic                        p_v;
   logic [2:0][TRANS_WIDTH-1:0] p_trans;
   logic [2:0][31:0]            p_rot;
   logic [RSP_W-1:0]            p_data;

   logic                        out_v_ff, sk_v_ff;
   logic [RSP_W-1:0]            out_d_ff, sk_d_ff;
   logic                        take;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         obs_t_ff  <= '0;
         obs_r_ff  <= {16'd0, 16'd0, 16'd0, 16'd16384};
         weight_ff <= 16'd256;
      end else if (csr_valid) begin
         case (csr_index)
            REG_OBS_TX: obs_t_ff[0] <= csr_wdata;
            REG_OBS_TY: obs_t_ff[1] <= csr_wdata;
            REG_OBS_TZ: obs_t_ff[2] <= csr_wdata;
            REG_OBS_RW: obs_r_ff[0] <= csr_wdata[15:0];
            REG_OBS_RX: obs_r_ff[1] <= csr_wdata[15:0];
            REG_OBS_RY: obs_r_ff[2] <= csr_wdata[15:0];
            REG_OBS_RZ: obs_r_ff[3] <= csr_wdata[15:0];
            REG_WEIGHT: weight_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign adv        = !sk_v_ff;
   assign req_tready = adv;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e_dv_in[i] = DV_W'($signed(req_tdata[128 + (3+i)*TRANS_WIDTH +: TRANS_WIDTH]))
                    - DV_W'($signed(req_tdata[128 + i*TRANS_WIDTH +: TRANS_WIDTH]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (adv) begin
         e_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_quat_ff <= req_tdata[127:0];
         e_dv_ff   <= e_dv_in;
      end
   end

   rpr_norm #(
      .SIDE_W    (3*DV_W)
   ) u_norm (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (e_v_ff),
      .in_quat   (e_quat_ff),
      .in_side   (e_dv_ff),
      .out_valid (n_v),
      .out_quat  (n_quat),
      .out_side  (n_side)
   );

   rpr_geom #(
      .TRANS_WIDTH (TRANS_WIDTH)
   ) u_geom (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (n_v),
      .in_quat   (n_quat),
      .in_dv     (n_side),
      .out_valid (g_v),
      .out_rel   (g_rel),
      .out_rt    (g_rt),
      .out_dv    (g_dv)
   );

   rpr_resid #(
      .TRANS_WIDTH (TRANS_WIDTH)
   ) u_resid (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (g_v),
      .in_rel    (g_rel),
      .in_rt     (g_rt),
      .in_dv     (g_dv),
      .obs_trans (obs_t_ff),
      .obs_rot   (obs_r_ff),
      .weight    (weight_ff),
      .out_valid (p_v),
      .out_trans (p_trans),
      .out_rot   (p_rot)
   );

   assign p_data = RSP_W'({p_rot, p_trans});
   assign take   = out_v_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else if (sk_v_ff) begin
         if (take) begin
            sk_v_ff <= 1'b0;
         end
      end else if (!out_v_ff || take) begin
         out_v_ff <= p_v;
      end else if (p_v) begin
         sk_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (sk_v_ff) begin
         if (take) begin
            out_d_ff <= sk_d_ff;
         end
      end else if (!out_v_ff || take) begin
         out_d_ff <= p_data;
      end else begin
         sk_d_ff <= p_data;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      sk_v_ff |-> out_v_ff)
      else $error("skid holds a response while output register is empty");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(sk_v_ff) |-> $past(out_v_ff && !rsp_tready))
      else $error("skid filled without a stalled output");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      sk_v_ff && rsp_tready |=> !sk_v_ff && out_v_ff)
      else $error("skid failed to drain into output register");

endmodule
`default_nettype wire
